>>> hw/rtl/ptm_pkg.sv
// Shared types, sizes and codes for the page table mapper.
package ptm_pkg;

  // Table geometry
  localparam int MAX_PROCESSES = 3;
  localparam int TABLE_DEPTH   = 1024;

  localparam int PROC_W   = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
  localparam int MEM_DEPTH = MAX_PROCESSES * TABLE_DEPTH;
  localparam int MEM_AW   = $clog2(MEM_DEPTH);

  // Field widths
  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_W     = 31;
  localparam int LEN_W      = 7;
  localparam int PAGE_W     = 19;
  localparam int FRAME_W    = 20;
  localparam int FCNT_W     = 21;
  localparam int ENTRIES_W  = 11;

  localparam logic [FCNT_W-1:0] FRAMES_MAX = 21'h100000;

  // Register map (word index)
  localparam logic [0:0] REG_FREE_FRAMES = 1'b0;

  typedef enum logic [1:0] {
    OUT_HIT    = 2'd0,
    OUT_MAPPED = 2'd1,
    OUT_FAULT  = 2'd2,
    OUT_FULL   = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    WS_IDLE,
    WS_SEARCH,
    WS_FINISH
  } walk_state_t;

  typedef struct packed {
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
  } entry_t;

  typedef struct packed {
    outcome_t               outcome;
    logic [PAGE_W-1:0]      page_number;
    logic [FRAME_W-1:0]     frame_number;
    logic                   last_of_run;
    logic [ENTRIES_W-1:0]   table_entries;
  } result_t;

endpackage

>>> hw/rtl/ptm_ram.sv
// Simple dual-port RAM: one write port, one read port, registered read data.
module ptm_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/ptm_walker.sv
// Page table walker: linear search, frame allocation and table update.
module ptm_walker
  import ptm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROC_W-1:0] start_proc,
  input  logic [PAGE_W-1:0] start_page,
  input  logic [PAGE_W-1:0] start_second,
  input  logic              start_two,
  input  logic              out_free,
  input  logic              cfg_we,
  input  logic [FCNT_W-1:0] cfg_frames,
  output logic              idle,
  output logic              res_load,
  output result_t           res
);

  walk_state_t state, state_next;

  logic [PROC_W-1:0] proc_r, proc_next;
  logic [PAGE_W-1:0] page, page_next;
  logic [PAGE_W-1:0] second, second_next;
  logic              has_second, has_second_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic [CNT_W-1:0]  used, used_next;
  logic              rd_pend, rd_pend_next;
  logic              hit, hit_next;
  logic [FRAME_W-1:0] hit_frame, hit_frame_next;

  logic [CNT_W-1:0]  entry_count [MAX_PROCESSES];
  logic [FCNT_W-1:0] next_frame;
  logic [FCNT_W-1:0] frames_left;

  logic              map;
  logic              rd_en;
  logic              issue;
  logic [MEM_AW-1:0] base;
  logic [MEM_AW-1:0] rd_addr;
  logic [MEM_AW-1:0] wr_addr;
  logic [$bits(entry_t)-1:0] rd_data;
  entry_t            rd_entry;
  entry_t            wr_entry;
  logic [CNT_W-1:0]  count_after;
  logic [31:0]       count_wide;

  // Table memory addressing
  assign base     = MEM_AW'(proc_r) * MEM_AW'(TABLE_DEPTH);
  assign rd_addr  = base + MEM_AW'(idx);
  assign wr_addr  = base + MEM_AW'(used);
  assign rd_entry = entry_t'(rd_data);
  assign wr_entry = '{page: page, frame: next_frame[FRAME_W-1:0]};
  assign issue    = (idx < used);
  assign idle     = (state == WS_IDLE);

  ptm_ram #(
    .DEPTH (MEM_DEPTH),
    .WIDTH ($bits(entry_t)),
    .AW    (MEM_AW)
  ) u_table (
    .clk   (clk),
    .we    (map),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Next state, search datapath and result
  always_comb begin
    state_next      = state;
    proc_next       = proc_r;
    page_next       = page;
    second_next     = second;
    has_second_next = has_second;
    idx_next        = idx;
    used_next       = used;
    rd_pend_next    = 1'b0;
    hit_next        = hit;
    hit_frame_next  = hit_frame;
    rd_en           = 1'b0;
    map             = 1'b0;
    res_load        = 1'b0;
    res             = '0;
    count_after     = used;
    count_wide      = '0;
    unique case (state)
      WS_IDLE: begin
        if (start) begin
          proc_next       = start_proc;
          page_next       = start_page;
          second_next     = start_second;
          has_second_next = start_two;
          idx_next        = '0;
          used_next       = entry_count[start_proc];
          hit_next        = 1'b0;
          state_next      = WS_SEARCH;
        end
      end
      WS_SEARCH: begin
        // Compare the entry read last cycle, issue the next read
        if (rd_pend && (rd_entry.page == page)) begin
          hit_next       = 1'b1;
          hit_frame_next = rd_entry.frame;
          state_next     = WS_FINISH;
        end else if (!issue && !rd_pend) begin
          state_next = WS_FINISH;
        end else begin
          rd_en        = issue;
          rd_pend_next = issue;
          if (issue) begin
            idx_next = idx + 1'b1;
          end
        end
      end
      WS_FINISH: begin
        if (out_free) begin
          res_load        = 1'b1;
          res.page_number = page;
          res.last_of_run = !has_second;
          priority if (hit) begin
            res.outcome      = OUT_HIT;
            res.frame_number = hit_frame;
          end else if (frames_left == '0) begin
            res.outcome = OUT_FAULT;
          end else if (used == CNT_W'(TABLE_DEPTH)) begin
            res.outcome = OUT_FULL;
          end else begin
            res.outcome      = OUT_MAPPED;
            res.frame_number = next_frame[FRAME_W-1:0];
            map              = 1'b1;
            count_after      = used + 1'b1;
          end
          count_wide        = 32'(count_after);
          res.table_entries = count_wide[ENTRIES_W-1:0];
          // Move on to the second page or finish the item
          if (has_second) begin
            page_next       = second;
            has_second_next = 1'b0;
            idx_next        = '0;
            used_next       = count_after;
            hit_next        = 1'b0;
            state_next      = WS_SEARCH;
          end else begin
            state_next = WS_IDLE;
          end
        end
      end
      default: state_next = WS_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= WS_IDLE;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_pend_next;
    end
  end

  // Search context
  always_ff @(posedge clk) begin
    proc_r     <= proc_next;
    page       <= page_next;
    second     <= second_next;
    has_second <= has_second_next;
    idx        <= idx_next;
    used       <= used_next;
    hit        <= hit_next;
    hit_frame  <= hit_frame_next;
  end

  // Table fill counts and frame pool
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < MAX_PROCESSES; p++) begin
        entry_count[p] <= '0;
      end
      next_frame  <= '0;
      frames_left <= '0;
    end else begin
      if (map) begin
        entry_count[proc_r] <= count_after;
        next_frame          <= next_frame + 1'b1;
        frames_left         <= frames_left - 1'b1;
      end
      if (cfg_we) begin
        frames_left <= cfg_frames;
      end
    end
  end

endmodule

>>> hw/rtl/page_table_mapper_top.sv
// Top level of the page table mapper: register port, item split and result register.
//
// Each input item names a process, a virtual address and a length, and yields one
// result item per 4 KB page touched (one or two), the last one marked. Items whose
// process is out of range are taken and give no result. The page table search reads
// one table entry per cycle from the table memory, up to N entries per page where N
// is the number of entries in that process's table (at most 1024); one item is
// worked on at a time, and in_stall stays high until the walker is back to idle.
// Finished results wait in an output register, so the search of the next page runs
// while a stalled output holds the last result. The table memory needs no clearing
// pass: only entries below each process's fill count are read.
// free_frames (address 0) reloads the pool of frames left; write it only when idle.
module page_table_mapper_top
  import ptm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Input items
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           process_id,
  input  logic [ADDR_W-1:0]    address,
  input  logic [LEN_W-1:0]     length,
  // Result items
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           outcome,
  output logic [PAGE_W-1:0]    page_number,
  output logic [FRAME_W-1:0]   frame_number,
  output logic                 last_of_run,
  output logic [ENTRIES_W-1:0] table_entries,
  // Register port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [FCNT_W-1:0] free_frames;
  logic [FCNT_W-1:0] wr_frames;
  logic              cfg_we;

  logic              idle;
  logic              accept;
  logic              start;
  logic [LEN_W-1:0]  len_eff;
  logic [31:0]       end_addr;
  logic [PAGE_W-1:0] first_page;
  logic              two_pages;

  logic              out_free;
  logic              res_load;
  result_t           res;
  result_t           res_q;

  // Register port
  assign pready    = 1'b1;
  assign wr_frames = (pwdata[FCNT_W-1:0] > FRAMES_MAX) ? FRAMES_MAX : pwdata[FCNT_W-1:0];
  assign cfg_we    = psel && penable && pwrite && pready && (paddr[2] == REG_FREE_FRAMES);
  assign prdata    = (paddr[2] == REG_FREE_FRAMES) ? 32'(free_frames) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      free_frames <= '0;
    end else if (cfg_we) begin
      free_frames <= wr_frames;
    end
  end

  // Split the access into its first and last page
  assign in_stall   = !idle;
  assign accept     = in_valid && !in_stall;
  assign start      = accept && (32'(process_id) < MAX_PROCESSES);
  assign len_eff    = (length == '0) ? LEN_W'(1) : length;
  assign end_addr   = {1'b0, address} + 32'(len_eff) - 32'd1;
  assign first_page = address[ADDR_W-1:PAGE_SHIFT];
  assign two_pages  = (end_addr[31:PAGE_SHIFT] != {1'b0, first_page});

  ptm_walker u_walker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .start_proc   (PROC_W'(process_id)),
    .start_page   (first_page),
    .start_second (end_addr[ADDR_W-1:PAGE_SHIFT]),
    .start_two    (two_pages),
    .out_free     (out_free),
    .cfg_we       (cfg_we),
    .cfg_frames   (wr_frames),
    .idle         (idle),
    .res_load     (res_load),
    .res          (res)
  );

  // Result register
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_q <= res;
    end
  end

  assign outcome       = res_q.outcome;
  assign page_number   = res_q.page_number;
  assign frame_number  = res_q.frame_number;
  assign last_of_run   = res_q.last_of_run;
  assign table_entries = res_q.table_entries;

endmodule

>>> bench/page_table_mapper_top_tb.sv
// Self-checking testbench for page_table_mapper_top: directed, table-fill and random accesses.
`timescale 1ns / 100ps

module page_table_mapper_top_tb
  import ptm_pkg::*;
();

  // Worst walk of one item plus margin: two full-table searches
  localparam int DRAIN_CYCLES = 2 * (TABLE_DEPTH + 3) + 64;
  localparam int HOLD_CYCLES  = 3000;
  localparam int HALF_ITEMS   = 145;

  // Page table predictor and the queue of result items it expects
  class page_map_scoreboard;
    logic [PAGE_W-1:0]  page_tbl  [MAX_PROCESSES][TABLE_DEPTH];
    logic [FRAME_W-1:0] frame_tbl [MAX_PROCESSES][TABLE_DEPTH];
    int                 fill      [MAX_PROCESSES];
    logic [FCNT_W-1:0]  frames_issued;
    logic [FCNT_W-1:0]  frames_free;
    logic [FCNT_W-1:0]  free_reg;
    result_t            pending_q [$];
    int                 errors;

    function new();
      foreach (fill[i]) fill[i] = 0;
      frames_issued = '0;
      frames_free   = '0;
      free_reg      = '0;
      errors        = 0;
    endfunction

    // Keep the low 21 bits, clamp to the frame ceiling, reload the pool
    function void load_free_frames(logic [31:0] value);
      logic [FCNT_W-1:0] v;
      v = value[FCNT_W-1:0];
      if (v > FRAMES_MAX) v = FRAMES_MAX;
      free_reg    = v;
      frames_free = v;
    endfunction

    // Search one process's table for a page; allocate a frame on a miss
    function result_t map_page(int p, logic [PAGE_W-1:0] pg);
      result_t r;
      bit      found;
      int      i;
      found          = 1'b0;
      r.outcome      = OUT_HIT;
      r.page_number  = pg;
      r.frame_number = '0;
      r.last_of_run  = 1'b0;
      for (i = 0; i < fill[p] && !found; i++) begin
        if (page_tbl[p][i] == pg) begin
          found          = 1'b1;
          r.frame_number = frame_tbl[p][i];
        end
      end
      if (found) begin
        r.outcome = OUT_HIT;
      end else if (frames_free == 0) begin
        r.outcome = OUT_FAULT;
      end else if (fill[p] >= TABLE_DEPTH) begin
        r.outcome = OUT_FULL;
      end else begin
        r.frame_number        = frames_issued[FRAME_W-1:0];
        page_tbl[p][fill[p]]  = pg;
        frame_tbl[p][fill[p]] = r.frame_number;
        fill[p]++;
        frames_issued++;
        frames_free--;
        r.outcome = OUT_MAPPED;
      end
      r.table_entries = ENTRIES_W'(fill[p]);
      return r;
    endfunction

    // Expand an accepted access into one expected item per page touched
    function void note_access(logic [1:0] p, logic [ADDR_W-1:0] addr,
                              logic [LEN_W-1:0] len);
      logic [31:0]      end_addr;
      logic [LEN_W-1:0] n;
      result_t          r;
      if (p >= MAX_PROCESSES) return;
      n        = (len == 0) ? LEN_W'(1) : len;
      end_addr = {1'b0, addr} + 32'(n) - 32'd1;
      r        = map_page(p, addr[ADDR_W-1:PAGE_SHIFT]);
      if (end_addr[31:PAGE_SHIFT] != 20'(addr[ADDR_W-1:PAGE_SHIFT])) begin
        pending_q.push_back(r);
        r = map_page(p, end_addr[ADDR_W-1:PAGE_SHIFT]);
      end
      r.last_of_run = 1'b1;
      pending_q.push_back(r);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      end
    endfunction

    // Match a result item against the oldest expectation
    function void check_result(result_t got);
      result_t want;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result item, page %0h outcome %0d", $time,
                 got.page_number, got.outcome);
        return;
      end
      want = pending_q.pop_front();
      compare_field("outcome", 32'(want.outcome), 32'(got.outcome));
      compare_field("page_number", 32'(want.page_number), 32'(got.page_number));
      compare_field("frame_number", 32'(want.frame_number), 32'(got.frame_number));
      compare_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
      compare_field("table_entries", 32'(want.table_entries), 32'(got.table_entries));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           process_id;
  logic [ADDR_W-1:0]    address;
  logic [LEN_W-1:0]     length;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           outcome;
  logic [PAGE_W-1:0]    page_number;
  logic [FRAME_W-1:0]   frame_number;
  logic                 last_of_run;
  logic [ENTRIES_W-1:0] table_entries;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [2:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  page_map_scoreboard sb;
  result_t            seen_result;
  bit                 gaps_on;
  int                 hold_count = 0;
  logic [PAGE_W-1:0]  hot_pages [16];

  page_table_mapper_top uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .process_id    (process_id),
    .address       (address),
    .length        (length),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .outcome       (outcome),
    .page_number   (page_number),
    .frame_number  (frame_number),
    .last_of_run   (last_of_run),
    .table_entries (table_entries),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  initial begin
    #100_000_000;
    $display("page_table_mapper_top_tb NOT OK");
    $finish;
  end

  // Stall the result side at random, or hold it off for a long stretch on request
  initial begin : result_sink
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_count != hold_seen) begin
        hold_left = HOLD_CYCLES;
        hold_seen = hold_count;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= gaps_on && ($urandom_range(99) < 16);
      end
    end
  end

  // Check every accepted result item
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      seen_result.outcome       = outcome_t'(outcome);
      seen_result.page_number   = page_number;
      seen_result.frame_number  = frame_number;
      seen_result.last_of_run   = last_of_run;
      seen_result.table_entries = table_entries;
      sb.check_result(seen_result);
    end
  end

  // Offer one access, idling first at random, and hold it until taken
  task automatic send_access(input logic [1:0] p, input logic [ADDR_W-1:0] a,
                             input logic [LEN_W-1:0] l);
    if (gaps_on) begin
      while ($urandom_range(99) < 16) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    process_id <= p;
    address    <= a;
    length     <= l;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_access(p, a, l);
  endtask

  // Drop valid, wait for all expected items, then let any walk finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write free_frames, then read it back
  task automatic write_free_frames(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_FREE_FRAMES, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.load_free_frames(value);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== 32'(sb.free_reg)) begin
      sb.errors++;
      $display("%0t: free_frames readback mismatch, expected %0h, got %0h", $time,
               32'(sb.free_reg), prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Random accesses: mostly hot pages, some page-crossing, a few ignored processes
  task automatic drive_random_accesses(input int count, input int quiet_items,
                                       input int hold_at);
    int                done;
    int                pick;
    logic [1:0]        p;
    logic [PAGE_W-1:0] pg;
    logic [11:0]       off;
    done = 0;
    while (done < count) begin
      gaps_on = (done >= quiet_items);
      pick    = $urandom_range(99);
      p       = (pick < 40) ? 2'd0 : (pick < 80) ? 2'd1 : (pick < 90) ? 2'd2 : 2'd3;
      pg      = ($urandom_range(99) < 65) ? hot_pages[$urandom_range(15)]
                                          : PAGE_W'($urandom);
      off     = ($urandom_range(99) < 30) ? 12'($urandom_range(4095, 3990))
                                          : 12'($urandom);
      send_access(p, {pg, off}, LEN_W'($urandom_range(127)));
      if (p < MAX_PROCESSES) begin
        done++;
        if (done == hold_at) hold_count++;
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin : stimulus
    int k;
    int off;
    sb         = new();
    rst        = 1'b1;
    in_valid   = 1'b0;
    process_id = '0;
    address    = '0;
    length     = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    gaps_on    = 1'b1;
    foreach (hot_pages[i]) hot_pages[i] = PAGE_W'($urandom);
    hot_pages[0] = '0;
    hot_pages[1] = '1;
    hot_pages[2] = 19'h2AAAA;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Pool empty out of reset: fault; out-of-range process: ignored
    send_access(2'd0, 31'h0000_0000, 7'd1);
    send_access(2'd3, 31'h7FFF_FFFF, 7'd127);
    wait_idle();

    // Oversized value clamps to the frame ceiling
    write_free_frames(32'hFFFF_FFFF);
    send_access(2'd0, 31'h0000_0000, 7'd1);
    send_access(2'd0, 31'h0000_0010, 7'd1);
    send_access(2'd0, 31'h0000_0FFF, 7'd2);
    send_access(2'd1, 31'h0000_0FFF, 7'd0);
    send_access(2'd1, 31'h7FFF_FFFF, 7'd99);
    send_access(2'd1, 31'h7FFF_FF80, 7'd127);
    send_access(2'd2, 31'h2AAA_AAAA, 7'd85);
    send_access(2'd2, 31'h5555_5555, 7'd42);
    send_access(2'd3, 31'h1234_5678, 7'd5);
    send_access(2'd2, 31'h2AAA_AAAA, 7'd1);
    wait_idle();

    // One frame left: a two-page access maps the first and faults the second
    write_free_frames(32'd1);
    send_access(2'd0, 31'h0000_5FF0, 7'd99);
    send_access(2'd0, 31'h0000_5000, 7'd1);
    send_access(2'd0, 31'h0000_7000, 7'd1);
    wait_idle();

    // Empty pool: hits still hit, misses fault
    write_free_frames(32'd0);
    send_access(2'd1, 31'h7FFF_F000, 7'd1);
    send_access(2'd1, 31'h0012_3456, 7'd10);
    wait_idle();

    // Fill process 2's table with page-crossing accesses to distinct pages
    write_free_frames(32'h0010_0000);
    k = 0;
    while (sb.fill[2] < TABLE_DEPTH) begin
      off = $urandom_range(4095, 3998);
      send_access(2'd2, {PAGE_W'(19'h40000 + 2 * k), 12'(off)},
                  LEN_W'($urandom_range(99, 4097 - off)));
      k++;
    end
    send_access(2'd2, 31'h3FFF_F000, 7'd1);
    send_access(2'd2, 31'h2AAA_AAAA, 7'd1);
    send_access(2'd2, 31'h2AAA_AFFF, 7'd2);
    wait_idle();

    // Full table with an empty pool reports a fault
    write_free_frames(32'd0);
    send_access(2'd2, 31'h3FFF_F000, 7'd1);
    wait_idle();

    // Random part, first half with a quiet stretch and a long result hold-off
    write_free_frames({11'h7FF, 21'($urandom_range(250, 80))});
    drive_random_accesses(HALF_ITEMS, 60, 90);
    wait_idle();

    // Second half with a small pool so misses run into faults
    write_free_frames(32'($urandom_range(40)));
    drive_random_accesses(HALF_ITEMS, 0, 0);
    wait_idle();

    if (sb.errors == 0) begin
      $display("page_table_mapper_top_tb OK");
    end else begin
      $display("page_table_mapper_top_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/ptm_pkg.sv
hw/rtl/ptm_ram.sv
hw/rtl/ptm_walker.sv
hw/rtl/page_table_mapper_top.sv
bench/page_table_mapper_top_tb.sv
